// ----- rtl/tre_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tre_pkg
// Shared types and constants of the pulse-period tachometer.
// ----------------------------------------------------------------------------
package tre_pkg;

  localparam int STAMP_DEPTH     = 3;
  localparam int TIME_W          = 48;
  localparam int SPEED_FRAC_BITS = 4;
  localparam int OP_W            = 2;
  localparam int SPEED_W         = 16;

  localparam int PPR_W = 7;
  localparam int DEB_W = 20;
  localparam int TMO_W = 32;
  localparam int MAX_W = 12;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // microseconds per minute, scaled into the speed fixed point
  localparam longint SPEED_NUM = 64'd60000000 << SPEED_FRAC_BITS;
  localparam int     QUOT_W    = $clog2(SPEED_NUM + 1);
  localparam int     PROD_W    = QUOT_W + PPR_W;
  localparam int     DIV_CNT_W = $clog2(QUOT_W);
  localparam int     HIST_CNT_W = $clog2(STAMP_DEPTH + 1);

  localparam logic [SPEED_W-1:0] SLEW_LOW_TH  = SPEED_W'(250 << SPEED_FRAC_BITS);
  localparam logic [SPEED_W-1:0] SLEW_HIGH_TH = SPEED_W'(600 << SPEED_FRAC_BITS);
  localparam logic [SPEED_W-1:0] STEP_LOW     = SPEED_W'(100 << SPEED_FRAC_BITS);
  localparam logic [SPEED_W-1:0] STEP_MID     = SPEED_W'(50 << SPEED_FRAC_BITS);
  localparam logic [SPEED_W-1:0] STEP_HIGH    = SPEED_W'(30 << SPEED_FRAC_BITS);
  localparam logic [SPEED_W-1:0] SPEED_MAX    =
    SPEED_W'(((1 << MAX_W) - 1) << SPEED_FRAC_BITS);

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [PPR_W-1:0] PPR_RST = PPR_W'(1);
  localparam logic [DEB_W-1:0] DEB_RST = DEB_W'(2000);
  localparam logic [TMO_W-1:0] TMO_RST = TMO_W'(2000000);
  localparam logic [MAX_W-1:0] MAX_RST = MAX_W'(1500);

  localparam logic [CFG_IDX_W-1:0] CFG_PPR      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RPM  = 2'd3;

  typedef enum logic [OP_W-1:0] {
    OP_PULSE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } tre_op_e;

  typedef enum logic [1:0] {
    KIND_RESULT = 2'd0,
    KIND_READ   = 2'd1,
    KIND_CLEAR  = 2'd2
  } tre_kind_e;

  typedef struct packed {
    logic [PPR_W-1:0] pulses_per_rev;
    logic [DEB_W-1:0] debounce_us;
    logic [TMO_W-1:0] timeout_us;
    logic [MAX_W-1:0] max_rpm;
  } tre_cfg_t;

  typedef struct packed {
    tre_kind_e         kind;
    logic              acc;
    logic              early;
    logic [TIME_W-1:0] d1;
    logic [TIME_W-1:0] d2;
  } tre_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/tre_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tre_front
// Takes input transactions, keeps the stamp history and debounce state, and
// hands one classified command per transaction to the command queue.
// ----------------------------------------------------------------------------
module tre_front
  import tre_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tre_cfg_t          cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OP_W-1:0]   in_op_i,
  input  logic [TIME_W-1:0] in_time_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output tre_cmd_t          q_cmd_o
);

  logic [TIME_W-1:0]     hist_q [STAMP_DEPTH];
  logic [TIME_W-1:0]     hist_d [STAMP_DEPTH];
  logic [TIME_W-1:0]     last_acc_q, last_acc_d;
  logic [HIST_CNT_W-1:0] cnt_q, cnt_d;
  logic [TIME_W-1:0]     since_last, age, d1, d2;
  logic                  deb_ok;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    since_last = in_time_i - last_acc_q;
    age        = in_time_i - hist_q[0];
    d1         = hist_q[0] - hist_q[1];
    d2         = hist_q[1] - hist_q[2];
    deb_ok     = since_last >= TIME_W'(cfg_i.debounce_us);

    q_cmd_o      = '0;
    q_cmd_o.kind = KIND_RESULT;
    q_cmd_o.d1   = d1;
    q_cmd_o.d2   = d2;
    case (in_op_i)
      OP_PULSE: q_cmd_o.acc = deb_ok;
      OP_READ: begin
        q_cmd_o.kind  = KIND_READ;
        q_cmd_o.early = (age > TIME_W'(cfg_i.timeout_us)) ||
                        (cnt_q != HIST_CNT_W'(STAMP_DEPTH)) ||
                        (d1 == '0) || (d2 == '0);
      end
      OP_CLEAR: q_cmd_o.kind = KIND_CLEAR;
      default: ;
    endcase
  end

  // history kept newest first, shifted on every stored edge
  always_comb begin
    hist_d     = hist_q;
    last_acc_d = last_acc_q;
    cnt_d      = cnt_q;
    if (q_push_o) begin
      if (in_op_i == OP_PULSE && deb_ok) begin
        for (int i = STAMP_DEPTH - 1; i > 0; i--) begin
          hist_d[i] = hist_q[i-1];
        end
        hist_d[0]  = in_time_i;
        last_acc_d = in_time_i;
        if (cnt_q != HIST_CNT_W'(STAMP_DEPTH)) begin
          cnt_d = cnt_q + 1'b1;
        end
      end else if (in_op_i == OP_CLEAR) begin
        last_acc_d = '0;
        cnt_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_acc_q <= '0;
      cnt_q      <= '0;
    end else begin
      last_acc_q <= last_acc_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hist_q <= hist_d;
  end

endmodule
`default_nettype wire

// ----- rtl/tre_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tre_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module tre_fifo
  import tre_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  tre_cmd_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output tre_cmd_t data_o
);

  tre_cmd_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_CW-1:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == FIFO_CW'(FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tre_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tre_back
// Executes queued commands: interval to speed through a multiply and a
// one-bit-per-cycle divider, averaging, slew limiting and the result register.
// ----------------------------------------------------------------------------
module tre_back
  import tre_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tre_cfg_t           cfg_i,
  input  logic               cmd_valid_i,
  input  tre_cmd_t           cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SPEED_W-1:0] out_rpm_o,
  output logic               out_acc_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_AVG  = 6'b001000,
    ST_SLEW = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [TIME_W-1:0]    d1_q, d1_d, d2_q, d2_d;
  logic                 sel_q, sel_d;
  logic [PROD_W-1:0]    prod_q, prod_d;
  logic                 big_q, big_d;
  logic [QUOT_W-1:0]    rem_q, rem_d, quo_q, quo_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [SPEED_W-1:0]   s1_q, s1_d, s2_q, s2_d, avg_q, avg_d, last_q, last_d;
  logic [SPEED_W-1:0]   res_rpm_q, res_rpm_d;
  logic                 res_acc_q, res_acc_d;
  logic                 out_valid_q, out_valid_d;
  logic [SPEED_W-1:0]   out_rpm_q, out_rpm_d;
  logic                 out_acc_q, out_acc_d;

  logic [TIME_W-1:0]    d_sel;
  logic [PPR_W-1:0]     ppr_eff;
  logic                 skip;
  logic [QUOT_W:0]      trial, divisor;
  logic                 ge;
  logic [QUOT_W-1:0]    quo_nx;
  logic [QUOT_W-1:0]    limit;
  logic [SPEED_W-1:0]   spd;
  logic [SPEED_W:0]     sum;
  logic [SPEED_W-1:0]   step, diff, slewed;

  assign pop_o       = (state_q == ST_IDLE) && cmd_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_rpm_o   = out_rpm_q;
  assign out_acc_o   = out_acc_q;

  // datapath pieces
  always_comb begin
    d_sel   = sel_q ? d2_q : d1_q;
    ppr_eff = (cfg_i.pulses_per_rev == '0) ? PPR_W'(1) : cfg_i.pulses_per_rev;
    // product beyond the numerator gives a zero quotient
    skip    = big_q || (prod_q > PROD_W'(SPEED_NUM));
    divisor = {1'b0, prod_q[QUOT_W-1:0]};
    trial   = {rem_q, quo_q[QUOT_W-1]};
    ge      = trial >= divisor;
    quo_nx  = {quo_q[QUOT_W-2:0], ge};
    limit   = QUOT_W'({cfg_i.max_rpm, {SPEED_FRAC_BITS{1'b0}}});
    spd     = (skip || quo_nx > limit) ? '0 : quo_nx[SPEED_W-1:0];
    sum     = {1'b0, s1_q} + {1'b0, s2_q};
    if (last_q < SLEW_LOW_TH) begin
      step = STEP_LOW;
    end else if (last_q <= SLEW_HIGH_TH) begin
      step = STEP_MID;
    end else begin
      step = STEP_HIGH;
    end
    diff = (avg_q > last_q) ? (avg_q - last_q) : (last_q - avg_q);
    if (last_q == '0 || avg_q == '0 || diff <= step) begin
      slewed = avg_q;
    end else if (avg_q > last_q) begin
      slewed = last_q + step;
    end else begin
      slewed = last_q - step;
    end
  end

  always_comb begin
    state_d     = state_q;
    d1_d        = d1_q;
    d2_d        = d2_q;
    sel_d       = sel_q;
    prod_d      = prod_q;
    big_d       = big_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    s1_d        = s1_q;
    s2_d        = s2_q;
    avg_d       = avg_q;
    last_d      = last_q;
    res_rpm_d   = res_rpm_q;
    res_acc_d   = res_acc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_rpm_d   = out_rpm_q;
    out_acc_d   = out_acc_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          d1_d      = cmd_i.d1;
          d2_d      = cmd_i.d2;
          sel_d     = 1'b0;
          res_rpm_d = '0;
          res_acc_d = 1'b0;
          state_d   = ST_OUT;
          case (cmd_i.kind)
            KIND_RESULT: res_acc_d = cmd_i.acc;
            KIND_CLEAR:  last_d = '0;
            KIND_READ: begin
              if (!cmd_i.early) begin
                state_d = ST_MUL;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        big_d   = |d_sel[TIME_W-1:QUOT_W];
        prod_d  = PROD_W'(d_sel[QUOT_W-1:0]) * PROD_W'(ppr_eff);
        rem_d   = '0;
        quo_d   = QUOT_W'(SPEED_NUM);
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = ge ? QUOT_W'(trial - divisor) : QUOT_W'(trial);
        quo_d = quo_nx;
        cnt_d = cnt_q + 1'b1;
        if (skip || cnt_q == DIV_CNT_W'(QUOT_W - 1)) begin
          if (!sel_q) begin
            s1_d    = spd;
            sel_d   = 1'b1;
            state_d = ST_MUL;
          end else begin
            s2_d    = spd;
            state_d = ST_AVG;
          end
        end
      end
      ST_AVG: begin
        avg_d   = (s1_q != '0 && s2_q != '0) ? sum[SPEED_W:1] : sum[SPEED_W-1:0];
        state_d = ST_SLEW;
      end
      ST_SLEW: begin
        res_rpm_d = slewed;
        last_d    = slewed;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_rpm_d   = res_rpm_q;
          out_acc_d   = res_acc_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d1_q      <= d1_d;
    d2_q      <= d2_d;
    sel_q     <= sel_d;
    prod_q    <= prod_d;
    big_q     <= big_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    cnt_q     <= cnt_d;
    s1_q      <= s1_d;
    s2_q      <= s2_d;
    avg_q     <= avg_d;
    res_rpm_q <= res_rpm_d;
    res_acc_q <= res_acc_d;
    out_rpm_q <= out_rpm_d;
    out_acc_q <= out_acc_d;
  end

`ifndef SYNTHESIS
  a_acc_no_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_acc_q) |-> (out_rpm_q == '0))
    else $error("pulse transaction carries a speed");

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_rpm_q <= SPEED_MAX))
    else $error("speed beyond the largest limit");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !skip) |-> (rem_q < prod_q[QUOT_W-1:0]))
    else $error("divider remainder not below divisor");

  a_last_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SLEW) |=> (last_q <= SPEED_MAX))
    else $error("last speed out of range");
`endif

endmodule
`default_nettype wire

// ----- rtl/tachometer_rpm_estimator_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tachometer_rpm_estimator_core
// Pulse-period tachometer with debounce, timeout, averaging and slew limit.
// ----------------------------------------------------------------------------
// usage
//   s_axis: one transaction per event, opcode in tuser (pulse edge, read,
//   clear), microsecond stamp in tdata. m_axis: exactly one result per input
//   transaction, in order: speed in 1/16 rpm (reads only) and the flag telling
//   whether a pulse edge was stored.
//   the front takes a transaction every cycle while its two-entry command
//   queue has room; the back works on one command at a time.
//   pulse, clear and early-zero reads go from idle straight to the output
//   state in the back. full reads pass twice through the shared 30-step
//   restoring divider (a multiply step and 30 quotient bits per interval),
//   then through averaging and slew limiting.
//   configuration writes (cfg_we_i) take effect at once; write only while the
//   block is idle.
//   reset empties the history, the queue and the output register and loads
//   the register defaults. a stalled m_axis holds its result; the back then
//   waits, the queue fills and s_axis_tready drops.
// ----------------------------------------------------------------------------
module tachometer_rpm_estimator_core
  import tre_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [47:0]           s_axis_tdata,  // [47:0] time_us
  input  logic [1:0]            s_axis_tuser,  // [1:0] opcode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata   // [15:0] rpm_q4, [16] pulse_accepted
);

  tre_cfg_t           cfg_q, cfg_d;
  logic               q_full, q_push, q_valid, q_pop;
  tre_cmd_t           q_cmd_in, q_cmd_out;
  logic [SPEED_W-1:0] rpm;
  logic               acc;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PPR:      cfg_d.pulses_per_rev = cfg_wdata_i[PPR_W-1:0];
        CFG_DEBOUNCE: cfg_d.debounce_us    = cfg_wdata_i[DEB_W-1:0];
        CFG_TIMEOUT:  cfg_d.timeout_us     = cfg_wdata_i[TMO_W-1:0];
        CFG_MAX_RPM:  cfg_d.max_rpm        = cfg_wdata_i[MAX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulses_per_rev <= PPR_RST;
      cfg_q.debounce_us    <= DEB_RST;
      cfg_q.timeout_us     <= TMO_RST;
      cfg_q.max_rpm        <= MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tre_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_op_i    (s_axis_tuser),
    .in_time_i  (s_axis_tdata),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_cmd_in)
  );

  tre_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_cmd_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_cmd_out)
  );

  tre_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd_out),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_rpm_o   (rpm),
    .out_acc_o   (acc)
  );

  assign m_axis_tdata = {7'd0, acc, rpm};

endmodule
`default_nettype wire

// ----- sim/rpm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpm_checker
// Watches the register port and both stream channels of the tachometer core,
// predicts one reading per accepted input transaction and compares each
// output transaction against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module rpm_checker
  import tre_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [47:0]           s_tdata_i,   // [47:0] time_us
  input  logic [1:0]            s_tuser_i,   // [1:0] opcode
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [23:0]           m_tdata_i,   // [15:0] rpm_q4, [16] pulse_accepted
  output int                    pending_o,
  output int                    fail_count_o,
  output int                    speeds_o,
  output int                    edges_o
);

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [SPEED_W-1:0] rpm_q4;
    logic               pulse_acc;
  } reading_t;

  localparam u64_t RPM_ONE = u64_t'(1) << SPEED_FRAC_BITS;
  localparam u64_t RPM_NUM = u64_t'(60000000) << SPEED_FRAC_BITS;

  // register copies
  logic [PPR_W-1:0] ppr_q;
  logic [DEB_W-1:0] deb_q;
  logic [TMO_W-1:0] tmo_q;
  logic [MAX_W-1:0] max_q;

  // tachometer state
  logic [TIME_W-1:0]  stamps [STAMP_DEPTH];
  int unsigned        newest_idx;
  int unsigned        stamps_held;
  logic [TIME_W-1:0]  last_edge_t;
  logic [SPEED_W-1:0] prev_speed;

  reading_t pending_readings [$];
  reading_t got;
  reading_t want;
  int       fail_count = 0;
  int       speeds     = 0;
  int       edges      = 0;

  function automatic void forget_history();
    foreach (stamps[i]) stamps[i] = '0;
    newest_idx  = 0;
    stamps_held = 0;
    last_edge_t = '0;
    prev_speed  = '0;
  endfunction

  function automatic u64_t interval_rpm(input logic [TIME_W-1:0] ivl, input u64_t ppr,
                                        input u64_t lim);
    u64_t q;
    q = RPM_NUM / (u64_t'(ivl) * ppr);
    return (q > lim) ? 0 : q;
  endfunction

  function automatic logic [SPEED_W-1:0] read_rpm(input logic [TIME_W-1:0] now);
    int unsigned       i1, i2, i3, n_ok;
    logic [TIME_W-1:0] age, d1, d2;
    u64_t              ppr, lim, s1, s2, avg, res, step, diff, last;
    i1  = newest_idx;
    i2  = (i1 == 0) ? STAMP_DEPTH - 1 : i1 - 1;
    i3  = (i2 == 0) ? STAMP_DEPTH - 1 : i2 - 1;
    age = now - stamps[i1];
    // stale, partly filled or zero-interval history: zero, speed kept
    if (age > TIME_W'(tmo_q) || stamps_held < STAMP_DEPTH) return '0;
    d1 = stamps[i1] - stamps[i2];
    d2 = stamps[i2] - stamps[i3];
    if (d1 == 0 || d2 == 0) return '0;
    ppr  = (ppr_q == 0) ? 1 : u64_t'(ppr_q);
    lim  = u64_t'(max_q) * RPM_ONE;
    s1   = interval_rpm(d1, ppr, lim);
    s2   = interval_rpm(d2, ppr, lim);
    n_ok = (s1 != 0) + (s2 != 0);
    avg  = (n_ok == 0) ? 0 : (s1 + s2) / n_ok;
    res  = avg;
    last = u64_t'(prev_speed);
    if (last != 0 && avg != 0) begin
      if (last < 250 * RPM_ONE) begin
        step = 100 * RPM_ONE;
      end else if (last <= 600 * RPM_ONE) begin
        step = 50 * RPM_ONE;
      end else begin
        step = 30 * RPM_ONE;
      end
      diff = (avg > last) ? avg - last : last - avg;
      if (diff > step) res = (avg > last) ? last + step : last - step;
    end
    prev_speed = res[SPEED_W-1:0];
    return prev_speed;
  endfunction

  function automatic reading_t predict_reading(input logic [OP_W-1:0] op,
                                               input logic [TIME_W-1:0] now);
    reading_t          r;
    logic [TIME_W-1:0] since;
    r = '0;
    case (op)
      OP_PULSE: begin
        since = now - last_edge_t;
        if (since >= TIME_W'(deb_q)) begin
          newest_idx         = (newest_idx + 1) % STAMP_DEPTH;
          stamps[newest_idx] = now;
          last_edge_t        = now;
          if (stamps_held < STAMP_DEPTH) stamps_held++;
          r.pulse_acc = 1'b1;
          edges++;
        end
      end
      OP_READ: begin
        r.rpm_q4 = read_rpm(now);
        if (r.rpm_q4 != 0) speeds++;
      end
      OP_CLEAR: forget_history();
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q = PPR_W'(1);
      deb_q = DEB_W'(2000);
      tmo_q = TMO_W'(2000000);
      max_q = MAX_W'(1500);
      forget_history();
      pending_readings.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PPR:      ppr_q = cfg_wdata_i[PPR_W-1:0];
          CFG_DEBOUNCE: deb_q = cfg_wdata_i[DEB_W-1:0];
          CFG_TIMEOUT:  tmo_q = cfg_wdata_i[TMO_W-1:0];
          CFG_MAX_RPM:  max_q = cfg_wdata_i[MAX_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        got.rpm_q4    = m_tdata_i[15:0];
        got.pulse_acc = m_tdata_i[16];
        if (pending_readings.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result rpm_q4=%0d accepted=%0b with nothing outstanding",
                     $time, got.rpm_q4, got.pulse_acc);
          fail_count++;
        end else begin
          want = pending_readings.pop_front();
          if (got.rpm_q4 !== want.rpm_q4 || got.pulse_acc !== want.pulse_acc) begin
            if (fail_count < 10)
              $display("%0t: mismatch rpm_q4 exp %0d got %0d, accepted exp %0b got %0b",
                       $time, want.rpm_q4, got.rpm_q4, want.pulse_acc, got.pulse_acc);
            fail_count++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        pending_readings.push_back(predict_reading(s_tuser_i, s_tdata_i));
    end
    pending_o    <= pending_readings.size();
    fail_count_o <= fail_count;
    speeds_o     <= speeds;
    edges_o      <= edges;
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the tachometer core: a directed run of edge, read
// and clear cases, then random bursts of edge trains, reads and clears under
// several register settings, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb;
  import tre_pkg::*;

  typedef longint unsigned u64_t;

  localparam logic [OP_W-1:0] OP_SPARE    = 2'd3;
  localparam int              HOLD_CYCLES = 400;
  localparam int              CYCLE_LIMIT = 500000;
  localparam int              PHASE_ITEMS = 90;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [47:0]           s_tdata   = '0;
  logic [1:0]            s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [23:0]           m_tdata;

  int pending;
  int fail_count;
  int speeds_seen;
  int edges_stored;
  int items_sent = 0;
  int cycle_cnt  = 0;
  bit calm       = 1'b0;
  bit hold_req   = 1'b0;

  logic [TIME_W-1:0] now_t = '0;
  u64_t              cur_ppr, cur_deb, cur_tmo, cur_max;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  tachometer_rpm_estimator_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  rpm_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .pending_o    (pending),
    .fail_count_o (fail_count),
    .speeds_o     (speeds_seen),
    .edges_o      (edges_stored)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] stamp);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= stamp;
    s_tuser  <= op;
    do @(posedge clk_i); while (!s_tready);
    items_sent++;
  endtask

  // waits past the last handshake until the registered count of pending results is zero
  task automatic wait_drained();
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic apply_settings(input u64_t ppr, input u64_t deb, input u64_t tmo,
                                input u64_t mx);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_PPR;
    cfg_wdata <= CFG_DATA_W'(ppr);
    @(posedge clk_i);
    cfg_idx   <= CFG_DEBOUNCE;
    cfg_wdata <= CFG_DATA_W'(deb);
    @(posedge clk_i);
    cfg_idx   <= CFG_TIMEOUT;
    cfg_wdata <= CFG_DATA_W'(tmo);
    @(posedge clk_i);
    cfg_idx   <= CFG_MAX_RPM;
    cfg_wdata <= CFG_DATA_W'(mx);
    @(posedge clk_i);
    cfg_we  <= 1'b0;
    cur_ppr = (ppr == 0) ? 1 : ppr;
    cur_deb = deb;
    cur_tmo = tmo;
    cur_max = mx;
  endtask

  task automatic send_burst();
    int unsigned       kind, rpm_tgt, off_max;
    u64_t              ivl, step_t;
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] stamp;
    calm = ($urandom_range(0, 4) == 0);
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      // edge train near a target speed, reads in between and after
      rpm_tgt = $urandom_range(20, int'(cur_max + cur_max / 4 + 20));
      ivl     = 60000000 / (cur_ppr * rpm_tgt);
      if (ivl < cur_deb) ivl = cur_deb + $urandom_range(0, 50);
      if ($urandom_range(0, 3) == 0) send_item(OP_CLEAR, now_t);
      repeat ($urandom_range(2, 5)) begin
        step_t = ivl - ivl / 16 + $urandom_range(0, int'(ivl / 8));
        if (step_t < cur_deb) step_t = cur_deb;
        now_t = now_t + TIME_W'(step_t);
        send_item(OP_PULSE, now_t);
        off_max = (cur_tmo < step_t / 2) ? int'(cur_tmo) : int'(step_t / 2);
        if ($urandom_range(0, 1) == 0)
          send_item(OP_READ, now_t + TIME_W'($urandom_range(0, off_max)));
      end
      off_max = (cur_tmo < ivl / 2) ? int'(cur_tmo) : int'(ivl / 2);
      repeat ($urandom_range(1, 3))
        send_item(OP_READ, now_t + TIME_W'($urandom_range(0, off_max)));
    end else if (kind == 7) begin
      // bouncing edges inside the debounce window
      repeat ($urandom_range(2, 4)) begin
        now_t = now_t + TIME_W'($urandom_range(0, int'(cur_deb)));
        send_item(OP_PULSE, now_t);
      end
      send_item(OP_READ, now_t);
    end else if (kind == 8) begin
      send_item(OP_READ, now_t + TIME_W'(cur_tmo));
      send_item(OP_READ, now_t + TIME_W'(cur_tmo) + TIME_W'($urandom_range(1, 1000)));
      op    = OP_W'($urandom_range(0, 2));
      stamp = TIME_W'({$urandom(), $urandom()});
      send_item(op, stamp);
      if (op == OP_PULSE) now_t = stamp;
    end else if ($urandom_range(0, 1) == 0) begin
      send_item(OP_CLEAR, now_t);
    end else begin
      // move the time base close to wrap-around
      now_t = '1 - TIME_W'($urandom_range(0, 200000));
    end
  endtask

  task automatic run_phase();
    int target;
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) send_burst();
    s_tvalid <= 1'b0;
    wait_drained();
  endtask

  // receiver: random stalls per transaction, plus one long hold on request
  initial begin
    int unsigned w;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      w = calm ? 0 : $urandom_range(0, 15);
      if (w != 0) begin
        m_tready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
    end
  end

  initial begin
    cur_ppr = 1;
    cur_deb = 2000;
    cur_tmo = 2000000;
    cur_max = 1500;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: empty history, first-edge debounce, spare opcode, wrap
    send_item(OP_READ, 48'd0);
    send_item(OP_PULSE, 48'd1000);
    send_item(OP_SPARE, 48'hFFFF_FFFF_FFFF);
    send_item(OP_PULSE, 48'hFFFF_FFFF_FFFF);
    send_item(OP_PULSE, 48'd59999);
    send_item(OP_PULSE, 48'd119999);
    send_item(OP_READ, 48'd120100);
    // one interval over the speed limit, then both over it
    send_item(OP_PULSE, 48'd149999);
    send_item(OP_READ, 48'd150000);
    send_item(OP_PULSE, 48'd169999);
    send_item(OP_READ, 48'd170000);
    send_item(OP_READ, 48'd2170000);
    // slew in the upper band
    send_item(OP_PULSE, 48'd239999);
    send_item(OP_PULSE, 48'd309999);
    send_item(OP_READ, 48'd310000);
    send_item(OP_PULSE, 48'd349999);
    send_item(OP_PULSE, 48'd389999);
    send_item(OP_READ, 48'd390000);
    // slew in the lower and middle bands after a clear
    send_item(OP_CLEAR, 48'd400000);
    send_item(OP_READ, 48'd400000);
    send_item(OP_PULSE, 48'd700000);
    send_item(OP_PULSE, 48'd1000000);
    send_item(OP_PULSE, 48'd1300000);
    send_item(OP_READ, 48'd1300000);
    send_item(OP_PULSE, 48'd1360000);
    send_item(OP_READ, 48'd1360000);
    send_item(OP_READ, 48'd1360000);
    now_t = 48'd1360000;
    s_tvalid <= 1'b0;
    wait_drained();

    // zero pulses per rev, no debounce (zero intervals), widest limits
    hold_req = 1'b1;
    apply_settings(0, 0, 64'hFFFF_FFFF, 4095);
    run_phase();
    apply_settings(64, 1048575, 2000000, 1);
    run_phase();
    // zero timeout: only reads at the newest stamp see a speed
    apply_settings(1, 100, 0, 1500);
    run_phase();
    hold_req = 1'b1;
    apply_settings(4, 500, 500000, 3000);
    run_phase();
    apply_settings($urandom_range(1, 64), $urandom_range(0, 20000),
                   $urandom_range(100000, 5000000), $urandom_range(200, 4095));
    run_phase();
    apply_settings(2, 2000, 2000000, 1500);
    run_phase();

    repeat (80) @(posedge clk_i);
    $display("covered %0d transactions over seven register settings", items_sent);
    $display("  %0d nonzero speed readings, %0d stored edges", speeds_seen, edges_stored);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
